@@ rtl/core/mme_pkg.sv @@
// Shared constants, codes and field widths for the matrix multiply engine.
// No dependencies; every other file of the engine but mme_ram uses it.
`timescale 1ns / 1ps

package mme_pkg;

  localparam int DIM_DEFAULT = 8;

  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 3;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 32;
  localparam int SUM_W   = 35;
  localparam int MODE_W  = 2;
  localparam int DIM_W   = 4;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 4;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // transaction codes on the input channel
  localparam logic [FUNC_W-1:0] FUNC_WR_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN  = 2'd2;

  // multiply modes
  localparam logic [MODE_W-1:0] MODE_AB  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ATB = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ABT = 2'd2;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_A_ROWS = 3'd1;
  localparam logic [CFG_IW-1:0] REG_A_COLS = 3'd2;
  localparam logic [CFG_IW-1:0] REG_B_ROWS = 3'd3;
  localparam logic [CFG_IW-1:0] REG_B_COLS = 3'd4;

endpackage

@@ rtl/core/mme_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/core/matrix_multiply_engine_top.sv @@
// Matrix multiply engine: two element stores in RAM and a multiply-accumulate pipeline.
// Depends on mme_pkg and mme_ram.
//
//   channel  direction  handshake            payload
//   in       slave      in_valid_i/ready_o   func, row, col, value
//   out      master     out_valid_o/ready_i  row, col, sum, error, last
//   cfg      slave      cfg_we_i             cfg_idx_i, cfg_data_i
//
// A run first enters the run state, then issues one multiply-accumulate per cycle, while the
// output is not stalled, through the single read port of each store; each product is
// registered (multiply), then accumulated (accumulate) into the output register. The next
// transaction is taken once the pipeline has drained. A dimension error gives one result
// on the next cycle. Output back-pressure freezes the whole pipeline.
// Stores are not cleared on reset; registers reset to 0 / 8 / 8 / 8 / 8.
`timescale 1ns / 1ps

module matrix_multiply_engine_top #(
  parameter int DIM = mme_pkg::DIM_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic        [mme_pkg::FUNC_W-1:0]   in_func_i,
  input  logic        [mme_pkg::IDX_W-1:0]    in_row_i,
  input  logic        [mme_pkg::IDX_W-1:0]    in_col_i,
  input  logic signed [mme_pkg::VAL_W-1:0]    in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic        [mme_pkg::IDX_W-1:0]    out_row_o,
  output logic        [mme_pkg::IDX_W-1:0]    out_col_o,
  output logic signed [mme_pkg::SUM_W-1:0]    out_sum_o,
  output logic                                out_error_o,
  output logic                                out_last_o,
  input  logic                                cfg_we_i,
  input  logic        [mme_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic        [mme_pkg::CFG_DW-1:0]   cfg_data_i
);

  import mme_pkg::*;

  localparam int CW = $clog2(DIM);
  localparam int AW = $clog2(DIM * DIM);
  localparam int EW = DIM_W + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  typedef struct packed {
    logic          first;
    logic          last_m;
    logic          last_elem;
    logic [CW-1:0] i;
    logic [CW-1:0] j;
  } tag_t;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    dim_ok = (d != '0) && (EW'(d) <= EW'(DIM));
  endfunction

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    addr = AW'(r) * AW'(DIM) + AW'(c);
  endfunction

  // configuration
  logic [MODE_W-1:0] mode_q;
  logic [DIM_W-1:0]  a_rows_q, a_cols_q, b_rows_q, b_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_AB;
      a_rows_q <= DIM_RESET;
      a_cols_q <= DIM_RESET;
      b_rows_q <= DIM_RESET;
      b_cols_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        REG_A_ROWS: a_rows_q <= cfg_data_i;
        REG_A_COLS: a_cols_q <= cfg_data_i;
        REG_B_ROWS: b_rows_q <= cfg_data_i;
        REG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shape of the result
  logic [DIM_W-1:0] nr, nc, nk;
  logic             shape_ok;

  always_comb begin
    nr       = a_rows_q;
    nc       = b_cols_q;
    nk       = a_cols_q;
    shape_ok = 1'b0;
    case (mode_q)
      MODE_AB: begin
        shape_ok = (a_cols_q == b_rows_q);
      end
      MODE_ATB: begin
        nr       = a_cols_q;
        nk       = a_rows_q;
        shape_ok = (a_rows_q == b_rows_q);
      end
      MODE_ABT: begin
        nc       = b_rows_q;
        shape_ok = (a_cols_q == b_cols_q);
      end
      default: shape_ok = 1'b0;
    endcase
    shape_ok = shape_ok && dim_ok(a_rows_q) && dim_ok(a_cols_q)
               && dim_ok(b_rows_q) && dim_ok(b_cols_q);
  end

  // sequencer and pipeline control
  logic          st_q, st_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, m_q, m_d;
  logic          v1_q, v2_q;
  tag_t          tag0, tag1_q, tag2_q;
  logic          adv, issue, in_acc, run_acc, wr_ok;
  logic          m_last, j_last, i_last;

  // pipeline moves unless a result is waiting and not taken
  assign adv        = !(out_valid_o && !out_ready_i);
  assign in_ready_o = (st_q == ST_IDLE) && !v1_q && !v2_q && adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign run_acc    = in_acc && (in_func_i == FUNC_RUN);
  assign issue      = (st_q == ST_RUN) && adv;

  assign m_last = (EW'(m_q) == EW'(nk) - EW'(1));
  assign j_last = (EW'(j_q) == EW'(nc) - EW'(1));
  assign i_last = (EW'(i_q) == EW'(nr) - EW'(1));

  assign tag0 = '{first: (m_q == '0), last_m: m_last, last_elem: i_last && j_last,
                  i: i_q, j: j_q};

  always_comb begin
    st_d = st_q;
    i_d  = i_q;
    j_d  = j_q;
    m_d  = m_q;
    if (run_acc && shape_ok) begin
      st_d = ST_RUN;
      i_d  = '0;
      j_d  = '0;
      m_d  = '0;
    end else if (issue) begin
      if (m_last) begin
        m_d = '0;
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            st_d = ST_IDLE;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end else begin
        m_d = m_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      i_q  <= '0;
      j_q  <= '0;
      m_q  <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      st_q <= st_d;
      i_q  <= i_d;
      j_q  <= j_d;
      m_q  <= m_d;
      if (adv) begin
        v1_q <= issue;
        v2_q <= v1_q;
      end
    end
  end

  // stores
  logic [AW-1:0]    wr_addr, a_raddr, b_raddr;
  logic [VAL_W-1:0] a_rdata, b_rdata;

  assign wr_ok   = (in_row_i < DIM) && (in_col_i < DIM);
  assign wr_addr = addr(CW'(in_row_i), CW'(in_col_i));

  always_comb begin
    case (mode_q)
      MODE_ATB: begin
        a_raddr = addr(m_q, i_q);
        b_raddr = addr(m_q, j_q);
      end
      MODE_ABT: begin
        a_raddr = addr(i_q, m_q);
        b_raddr = addr(j_q, m_q);
      end
      default: begin
        a_raddr = addr(i_q, m_q);
        b_raddr = addr(m_q, j_q);
      end
    endcase
  end

  mme_ram #(.WIDTH(VAL_W), .DEPTH(DIM * DIM)) u_a_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_func_i == FUNC_WR_A) && wr_ok),
    .waddr_i (wr_addr),
    .wdata_i (in_value_i),
    .re_i    (issue),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mme_ram #(.WIDTH(VAL_W), .DEPTH(DIM * DIM)) u_b_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_func_i == FUNC_WR_B) && wr_ok),
    .waddr_i (wr_addr),
    .wdata_i (in_value_i),
    .re_i    (issue),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // datapath: tags follow the read, then multiply, then accumulate
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag1_q <= tag0;
      tag2_q <= tag1_q;
      prod_q <= PROD_W'($signed(a_rdata)) * PROD_W'($signed(b_rdata));
    end
  end

  assign acc_d = tag2_q.first ? SUM_W'(prod_q) : acc_q + SUM_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      acc_q <= acc_d;
    end
  end

  // output register
  logic done;
  assign done = adv && v2_q && tag2_q.last_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (done || (run_acc && !shape_ok)) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_row_o   <= IDX_W'(tag2_q.i);
      out_col_o   <= IDX_W'(tag2_q.j);
      out_sum_o   <= acc_d;
      out_error_o <= 1'b0;
      out_last_o  <= tag2_q.last_elem;
    end else if (run_acc && !shape_ok) begin
      out_row_o   <= '0;
      out_col_o   <= '0;
      out_sum_o   <= '0;
      out_error_o <= 1'b1;
      out_last_o  <= 1'b1;
    end
  end

endmodule

@@ rtl/core/mme_checker.sv @@
// Port-level checks for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg and matrix_multiply_engine_top.
`timescale 1ns / 1ps

module mme_port_checks (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic        [mme_pkg::FUNC_W-1:0] in_func_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic        [mme_pkg::IDX_W-1:0]  out_row_o,
  input logic        [mme_pkg::IDX_W-1:0]  out_col_o,
  input logic signed [mme_pkg::SUM_W-1:0]  out_sum_o,
  input logic                              out_error_o,
  input logic                              out_last_o
);

  import mme_pkg::*;

  // a stalled result holds its valid, sum, last and error
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_sum_o)
    && $stable(out_last_o) && $stable(out_error_o))
    else $error("stalled result changed");

  // error result is a lone, zeroed, final transaction
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_error_o |-> out_last_o && (out_sum_o == '0)
    && (out_row_o == '0) && (out_col_o == '0))
    else $error("malformed error result");

  // input is only taken when the output register can take a new result
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("input ready while output blocked");

  // a transaction other than a run (a store write or an ignored code) never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_func_i != FUNC_RUN) |=> !out_valid_o)
    else $error("result after store write");

endmodule

bind matrix_multiply_engine_top mme_port_checks u_mme_port_checks (.*);

@@ sim/mme_checker.sv @@
// Scoreboard for the matrix multiply engine: mirrors the registers and both element
// stores, predicts every C element on a run and compares it with the output channel.
// Depends on mme_pkg.
`timescale 1ns / 1ps

module mme_checker #(
  parameter int DIM = mme_pkg::DIM_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic        [mme_pkg::FUNC_W-1:0] in_func_i,
  input  logic        [mme_pkg::IDX_W-1:0]  in_row_i,
  input  logic        [mme_pkg::IDX_W-1:0]  in_col_i,
  input  logic signed [mme_pkg::VAL_W-1:0]  in_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic        [mme_pkg::IDX_W-1:0]  out_row_i,
  input  logic        [mme_pkg::IDX_W-1:0]  out_col_i,
  input  logic signed [mme_pkg::SUM_W-1:0]  out_sum_i,
  input  logic                              out_error_i,
  input  logic                              out_last_i,
  input  logic                              cfg_we_i,
  input  logic        [mme_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic        [mme_pkg::CFG_DW-1:0] cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  import mme_pkg::*;

  typedef struct packed {
    logic        [IDX_W-1:0] row;
    logic        [IDX_W-1:0] col;
    logic signed [SUM_W-1:0] sum;
    logic                    error;
    logic                    last;
  } c_elem_t;

  logic signed [VAL_W-1:0] a_mem [DIM*DIM];
  logic signed [VAL_W-1:0] b_mem [DIM*DIM];
  logic        [MODE_W-1:0] mode_q;
  logic        [DIM_W-1:0]  a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  c_elem_t                  c_expected [$];
  int                       mismatches  = 0;
  int                       outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  function automatic bit dim_fits(input logic [DIM_W-1:0] d);
    return (d != '0) && (int'(d) <= DIM);
  endfunction

  task automatic push_elem(input int r, input int c, input longint s, input bit err,
                           input bit lst);
    c_elem_t e;
    e.row   = IDX_W'(r);
    e.col   = IDX_W'(c);
    e.sum   = SUM_W'(s);
    e.error = err;
    e.last  = lst;
    c_expected.push_back(e);
  endtask

  // full-precision dot products, row-major, last mark on the final element; one error element on a bad shape
  task automatic predict_product();
    int     nr, nc, nk;
    bit     ok;
    longint acc, x, y;
    ok = dim_fits(a_rows_q) && dim_fits(a_cols_q) && dim_fits(b_rows_q) &&
         dim_fits(b_cols_q);
    nr = 0;
    nc = 0;
    nk = 0;
    case (mode_q)
      MODE_AB: begin
        ok = ok && (a_cols_q == b_rows_q);
        nr = int'(a_rows_q); nc = int'(b_cols_q); nk = int'(a_cols_q);
      end
      MODE_ATB: begin
        ok = ok && (a_rows_q == b_rows_q);
        nr = int'(a_cols_q); nc = int'(b_cols_q); nk = int'(a_rows_q);
      end
      MODE_ABT: begin
        ok = ok && (a_cols_q == b_cols_q);
        nr = int'(a_rows_q); nc = int'(b_rows_q); nk = int'(a_cols_q);
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      push_elem(0, 0, 0, 1'b1, 1'b1);
      return;
    end
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int m = 0; m < nk; m++) begin
          case (mode_q)
            MODE_AB: begin
              x = longint'(a_mem[i*DIM+m]);
              y = longint'(b_mem[m*DIM+j]);
            end
            MODE_ATB: begin
              x = longint'(a_mem[m*DIM+i]);
              y = longint'(b_mem[m*DIM+j]);
            end
            default: begin
              x = longint'(a_mem[i*DIM+m]);
              y = longint'(b_mem[j*DIM+m]);
            end
          endcase
          acc += x * y;
        end
        push_elem(i, j, acc, 1'b0, (i == nr - 1) && (j == nc - 1));
      end
    end
  endtask

  task automatic note_failure(input string what, input c_elem_t want, input c_elem_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%0t: %s: expected row %0d col %0d sum %0d error %0b last %0b, ",
             $realtime, what, want.row, want.col, want.sum, want.error, want.last);
      $display("got row %0d col %0d sum %0d error %0b last %0b",
               got.row, got.col, got.sum, got.error, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    c_elem_t got, want;
    if (!rst_ni) begin
      mode_q   <= MODE_AB;
      a_rows_q <= DIM_RESET;
      a_cols_q <= DIM_RESET;
      b_rows_q <= DIM_RESET;
      b_cols_q <= DIM_RESET;
      c_expected.delete();
      outstanding = 0;
    end else begin
      // results first: one accepted in this cycle cannot stem from this cycle's input
      if (out_valid_i && out_ready_i) begin
        got.row   = out_row_i;
        got.col   = out_col_i;
        got.sum   = out_sum_i;
        got.error = out_error_i;
        got.last  = out_last_i;
        if (c_expected.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = c_expected.pop_front();
          if (got.row !== want.row || got.col !== want.col || got.sum !== want.sum ||
              got.error !== want.error || got.last !== want.last)
            note_failure("wrong result", want, got);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
          REG_A_ROWS: a_rows_q <= cfg_data_i;
          REG_A_COLS: a_cols_q <= cfg_data_i;
          REG_B_ROWS: b_rows_q <= cfg_data_i;
          REG_B_COLS: b_cols_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (in_func_i)
          FUNC_WR_A: begin
            if (int'(in_row_i) < DIM && int'(in_col_i) < DIM)
              a_mem[int'(in_row_i)*DIM + int'(in_col_i)] = in_value_i;
          end
          FUNC_WR_B: begin
            if (int'(in_row_i) < DIM && int'(in_col_i) < DIM)
              b_mem[int'(in_row_i)*DIM + int'(in_col_i)] = in_value_i;
          end
          FUNC_RUN: predict_product();
          default: ;
        endcase
      end
      outstanding = c_expected.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the matrix multiply engine: clock, reset, register set-up, input
// stimulus in bursts and a stalling receiver. Checking lives in mme_checker.
// Depends on mme_pkg, mme_checker and matrix_multiply_engine_top.
`timescale 1ns / 1ps

module tb_top;
  import mme_pkg::*;

  localparam int DIM          = DIM_DEFAULT;
  localparam int RANDOM_ITEMS = 100;
  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;
  localparam int DRAIN        = 40;

  // codes the package leaves unnamed
  localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic        [FUNC_W-1:0] in_func_i;
  logic        [IDX_W-1:0]  in_row_i;
  logic        [IDX_W-1:0]  in_col_i;
  logic signed [VAL_W-1:0]  in_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic        [IDX_W-1:0]  out_row_o;
  logic        [IDX_W-1:0]  out_col_o;
  logic signed [SUM_W-1:0]  out_sum_o;
  logic                     out_error_o;
  logic                     out_last_o;
  logic                     cfg_we_i;
  logic        [CFG_IW-1:0] cfg_idx_i;
  logic        [CFG_DW-1:0] cfg_data_i;

  int failures;
  int pending;
  int burst_left = 0;
  bit steady     = 1'b0;
  int hold_asks  = 0;
  int items_sent = 0;
  bit a_written [DIM*DIM];
  bit b_written [DIM*DIM];

  matrix_multiply_engine_top #(.DIM(DIM)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_func_i   (in_func_i),
    .in_row_i    (in_row_i),
    .in_col_i    (in_col_i),
    .in_value_i  (in_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_sum_o   (out_sum_o),
    .out_error_o (out_error_o),
    .out_last_o  (out_last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  mme_checker #(.DIM(DIM)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_func_i    (in_func_i),
    .in_row_i     (in_row_i),
    .in_col_i     (in_col_i),
    .in_value_i   (in_value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_i    (out_row_o),
    .out_col_i    (out_col_o),
    .out_sum_i    (out_sum_o),
    .out_error_i  (out_error_o),
    .out_last_i   (out_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (failures),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(VAL_W-1){1'b0}}};
      1:       return {1'b0, {(VAL_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 3);
      6, 7, 8:          return $urandom_range(1, DIM);
      default:          return DIM;
    endcase
  endfunction

  // one input transaction, with a random gap whenever a burst runs out
  task automatic send_item(input logic [FUNC_W-1:0] f, input int r, input int c,
                           input logic signed [VAL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (steady)
        gap = 0;
      else if ($urandom_range(0, 3) == 0)
        gap = $urandom_range(5, 20);
      else
        gap = $urandom_range(0, 3);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_func_i  <= f;
    in_row_i   <= IDX_W'(r);
    in_col_i   <= IDX_W'(c);
    in_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    if (f == FUNC_WR_A) a_written[r*DIM + c] = 1'b1;
    if (f == FUNC_WR_B) b_written[r*DIM + c] = 1'b1;
    if (f != FUNC_IGNORED) items_sent++;
  endtask

  task automatic random_write();
    send_item(($urandom_range(0, 1) == 0) ? FUNC_WR_A : FUNC_WR_B,
              $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1), rand_value());
  endtask

  // run payload is don't-care, so it is randomised too
  task automatic run_multiply();
    send_item(FUNC_RUN, $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
              VAL_W'($urandom));
  endtask

  // write every entry a run may read that has not been written yet
  task automatic fill_stores(input int ar, input int ac, input int br, input int bc);
    for (int r = 0; r < ar && r < DIM; r++)
      for (int c = 0; c < ac && c < DIM; c++)
        if (!a_written[r*DIM + c]) send_item(FUNC_WR_A, r, c, rand_value());
    for (int r = 0; r < br && r < DIM; r++)
      for (int c = 0; c < bc && c < DIM; c++)
        if (!b_written[r*DIM + c]) send_item(FUNC_WR_B, r, c, rand_value());
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic set_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic apply_shape(input logic [MODE_W-1:0] m, input int ar, input int ac,
                             input int br, input int bc);
    logic [CFG_DW-1:0] mode_word;
    // upper bits of the mode write are don't-care
    mode_word             = CFG_DW'($urandom);
    mode_word[MODE_W-1:0] = m;
    wait_idle();
    set_reg(REG_MODE, mode_word);
    set_reg(REG_A_ROWS, CFG_DW'(ar));
    set_reg(REG_A_COLS, CFG_DW'(ac));
    set_reg(REG_B_ROWS, CFG_DW'(br));
    set_reg(REG_B_COLS, CFG_DW'(bc));
    if ($urandom_range(0, 3) == 0)
      set_reg(CFG_IW'($urandom_range(int'(REG_B_COLS) + 1, (1 << CFG_IW) - 1)),
              CFG_DW'($urandom));
  endtask

  task automatic do_phase(input bit pressure);
    logic [MODE_W-1:0] m;
    int                kind, nr, nc, nk, ar, ac, br, bc, bad;
    kind = pressure ? 0 : $urandom_range(0, 9);
    m    = MODE_W'($urandom_range(0, 2));
    nr   = pick_size();
    nc   = pick_size();
    nk   = pick_size();
    if (pressure) begin
      m  = MODE_ABT;
      nr = 4;
      nc = 4;
      nk = 4;
    end
    case (m)
      MODE_AB:  begin ar = nr; ac = nk; br = nk; bc = nc; end
      MODE_ATB: begin ar = nk; ac = nr; br = nk; bc = nc; end
      default:  begin ar = nr; ac = nk; br = nc; bc = nk; end
    endcase
    if (kind == 7) begin
      // independent sizes, mostly a mismatch
      ar = pick_size();
      ac = pick_size();
      br = pick_size();
      bc = pick_size();
    end else if (kind == 8) begin
      bad = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(DIM + 1, (1 << DIM_W) - 1);
      case ($urandom_range(0, 3))
        0:       ar = bad;
        1:       ac = bad;
        2:       br = bad;
        default: bc = bad;
      endcase
    end else if (kind == 9) begin
      m = MODE_UNUSED;
    end
    steady = ($urandom_range(0, 3) == 0);
    apply_shape(m, ar, ac, br, bc);
    repeat ($urandom_range(0, 3)) random_write();
    if ($urandom_range(0, 5) == 0)
      send_item(FUNC_IGNORED, $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                rand_value());
    fill_stores(ar, ac, br, bc);
    if (pressure) hold_asks++;
    run_multiply();
    // keep offering transactions behind the run so the engine backs up
    if (pressure || $urandom_range(0, 1) == 1) begin
      repeat (pressure ? $urandom_range(3, 6) : $urandom_range(1, 4)) random_write();
      run_multiply();
    end
  endtask

  // receiver: changing stall styles, plus long hold-offs on request
  initial begin : receiver
    int style, span, tick, hold_served;
    out_ready_i = 1'b0;
    style       = 0;
    span        = 0;
    tick        = 0;
    hold_served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_asks) begin
        hold_served++;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span  = $urandom_range(16, 96);
        end
        span--;
        tick++;
        case (style)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 1) == 1);
          2:       out_ready_i <= ((tick % 4) != 3);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_func_i  = FUNC_WR_A;
    in_row_i   = '0;
    in_col_i   = '0;
    in_value_i = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_MODE;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // 1x1 products at the value extremes, an ignored func in between
    apply_shape(MODE_AB, 1, 1, 1, 1);
    send_item(FUNC_WR_A, 0, 0, {1'b1, {(VAL_W-1){1'b0}}});
    send_item(FUNC_WR_B, 0, 0, {1'b1, {(VAL_W-1){1'b0}}});
    run_multiply();
    send_item(FUNC_WR_A, 0, 0, {1'b0, {(VAL_W-1){1'b1}}});
    run_multiply();
    send_item(FUNC_IGNORED, DIM - 1, DIM - 1, '1);
    run_multiply();
    apply_shape(MODE_ATB, 1, 1, 1, 1);
    run_multiply();
    // error results: unused mode, size mismatch, sizes of zero and above range
    apply_shape(MODE_UNUSED, 1, 1, 1, 1);
    run_multiply();
    apply_shape(MODE_AB, 1, 2, 1, 1);
    run_multiply();
    apply_shape(MODE_AB, 0, 1, 1, 1);
    run_multiply();
    apply_shape(MODE_ABT, 1, 1, (1 << DIM_W) - 1, 1);
    run_multiply();
    // largest magnitude sum: full-length dot product of most negative values
    apply_shape(MODE_ABT, 1, DIM, 1, DIM);
    for (int c = 0; c < DIM; c++) begin
      send_item(FUNC_WR_A, 0, c, {1'b1, {(VAL_W-1){1'b0}}});
      send_item(FUNC_WR_B, 0, c, {1'b1, {(VAL_W-1){1'b0}}});
    end
    run_multiply();

    do_phase(1'b1);
    while (items_sent < RANDOM_ITEMS) do_phase(1'b0);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    if (failures == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ matrix_multiply_engine_top.f @@
rtl/core/mme_pkg.sv
rtl/core/mme_ram.sv
rtl/core/matrix_multiply_engine_top.sv
rtl/core/mme_checker.sv
sim/mme_checker.sv
sim/tb_top.sv
